@@ hw/rtl/square_wave_channel_macros.svh @@
// Assertion macros shared by the square wave channel RTL
`ifndef SQUARE_WAVE_CHANNEL_MACROS_SVH
`define SQUARE_WAVE_CHANNEL_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent in a cycle implies consequent in the same cycle
`define SWC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle
`define SWC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define SWC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/swc_pkg.sv @@
// Types, constants and duty table of the square wave channel
package swc_pkg;

    localparam int ALU_W   = 15;
    localparam int TIMER_W = 14;
    localparam int REM_W   = 13;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] REG_DUTY_LEN  = 2'd0;
    localparam logic [1:0] REG_VOLUME    = 2'd1;
    localparam logic [1:0] REG_FREQ_LO   = 2'd2;
    localparam logic [1:0] REG_FREQ_HI   = 2'd3;

    localparam logic [7:0] RST_DUTY_LEN = 8'hBF;
    localparam logic [7:0] RST_VOLUME   = 8'hF3;
    localparam logic [7:0] RST_FREQ_LO  = 8'h00;
    localparam logic [7:0] RST_FREQ_HI  = 8'hBF;

    localparam logic [11:0]        FREQ_BASE = 12'd2048;
    localparam logic [TIMER_W-1:0] RST_TIMER = 14'd1024;

    // Duty waveforms, bit n is the level at duty step n
    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

    typedef struct packed {
        logic       en;
        logic [1:0] idx;
        logic [7:0] data;
    } reg_wr_t;

    typedef struct packed {
        logic [TIMER_W-1:0] period;
        logic [1:0]         duty_sel;
        logic [3:0]         volume;
        logic               enabled;
    } reg_view_t;

endpackage

@@ hw/rtl/square_wave_channel.sv @@
// Square wave channel: four byte registers, tick-driven duty step timer and sequencer.
// Each input word is a register read, a register write or a tick with an 8-bit clock
// count, and gives exactly one result word carrying read data, the current sample and
// the enable flag. s_tready is high only while the sequencer is idle. Reads, writes
// and unused opcodes go straight to the output step; a tick that leaves the step timer
// running decrements it; a tick that expires the timer runs the 8 steps of a restoring
// divide of the overrun by the period through the one shared 15-bit subtractor.
// A finished result waits in the output register; the next word is accepted once it
// has been loaded there.
`include "square_wave_channel_macros.svh"

module square_wave_channel
    import swc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // opcode[1:0], reg_index[3:2], write_data[11:4],
                                  // clock_count[19:12], zero[23:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data[7:0], sample[11:8], channel_on[12],
                                  // zero[15:13]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DEC,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [1:0]         idx_reg, idx_next;
    logic [7:0]         clocks_reg, clocks_next;
    logic [7:0]         over_reg, over_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [2:0]         quo_reg, quo_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [2:0]         step_reg, step_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;

    logic [1:0]         in_op;
    logic [1:0]         in_idx;
    logic [7:0]         in_data;
    logic [7:0]         in_clocks;
    logic               s_accept;

    reg_wr_t            wr;
    reg_view_t          view;
    logic [7:0]         rd_data;
    logic [7:0]         rd_out;
    logic [3:0]         sample;
    logic [REM_W:0]     shifted;

    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_diff;
    logic               alu_borrow;

    assign in_op     = s_tdata[1:0];
    assign in_idx    = s_tdata[3:2];
    assign in_data   = s_tdata[11:4];
    assign in_clocks = s_tdata[19:12];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign wr.en   = s_accept && (in_op == OP_WRITE);
    assign wr.idx  = in_idx;
    assign wr.data = in_data;

    swc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_idx  (idx_reg),
        .rd_data (rd_data),
        .view    (view)
    );

    swc_sub u_sub (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    assign shifted = {rem_reg, over_reg[7]};
    assign rd_out  = (op_reg == OP_READ) ? rd_data : 8'd0;
    assign sample  = DUTY_PATTERN[view.duty_sel][step_reg] ? view.volume : 4'd0;

    // Operand select for the shared subtractor
    always_comb
    begin
        case (state_reg)
            ST_CMP:
            begin
                alu_a = {{(ALU_W-8){1'b0}}, clocks_reg};
                alu_b = {1'b0, timer_reg};
            end
            ST_DEC:
            begin
                alu_a = {1'b0, timer_reg};
                alu_b = {{(ALU_W-8){1'b0}}, clocks_reg};
            end
            ST_DIV:
            begin
                alu_a = {1'b0, shifted};
                alu_b = {1'b0, view.period};
            end
            ST_FIN:
            begin
                alu_a = {1'b0, view.period};
                alu_b = {2'b00, rem_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        clocks_next   = clocks_reg;
        over_next     = over_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        timer_next    = timer_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next     = in_op;
                    idx_next    = in_idx;
                    clocks_next = in_clocks;
                    // trigger reloads from the period held before this write
                    if (in_op == OP_WRITE && in_idx == REG_FREQ_HI && in_data[7])
                    begin
                        timer_next = view.period;
                    end
                    state_next = (in_op == OP_ADVANCE) ? ST_CMP : ST_OUT;
                end
            end
            ST_CMP:
            begin
                if (!alu_borrow)
                begin
                    // timer expired: divide the overrun by the period
                    over_next  = alu_diff[7:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                timer_next = alu_diff[TIMER_W-1:0];
                state_next = ST_OUT;
            end
            ST_DIV:
            begin
                rem_next  = alu_borrow ? shifted[REM_W-1:0] : alu_diff[REM_W-1:0];
                quo_next  = {quo_reg[1:0], !alu_borrow};
                over_next = {over_reg[6:0], 1'b0};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                timer_next = alu_diff[TIMER_W-1:0];
                step_next  = step_reg + 3'd1 + quo_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, view.enabled, sample, rd_out};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_READ;
            idx_reg      <= REG_DUTY_LEN;
            clocks_reg   <= '0;
            over_reg     <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            cnt_reg      <= '0;
            timer_reg    <= RST_TIMER;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            clocks_reg   <= clocks_next;
            over_reg     <= over_next;
            rem_reg      <= rem_next;
            quo_reg      <= quo_next;
            cnt_reg      <= cnt_next;
            timer_reg    <= timer_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SWC_ASSERT_IMP(a_timer_range, clk, rst_n, state_reg == ST_IDLE,
        timer_reg != '0 && timer_reg <= {1'b1, {(TIMER_W-1){1'b0}}},
        "step timer out of range")

    `SWC_ASSERT_IMP(a_rem_below_period, clk, rst_n, state_reg == ST_DIV,
        {1'b0, rem_reg} < view.period,
        "divider remainder not below period")

    `SWC_ASSERT_NEXT(a_out_from_seq, clk, rst_n, !m_tvalid_reg || m_tready,
        m_tvalid_reg == $past(state_reg == ST_OUT),
        "result launched outside output step")

endmodule

@@ hw/rtl/swc_sub.sv @@
// Shared subtractor of the square wave channel sequencer
module swc_sub
    import swc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] diff,
    output logic             borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

@@ hw/rtl/swc_regs.sv @@
// Register file of the square wave channel with period decode
module swc_regs
    import swc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  reg_wr_t    wr,
    input  logic [1:0] rd_idx,
    output logic [7:0] rd_data,
    output reg_view_t  view
);

    logic [7:0]  duty_len_reg;
    logic [7:0]  volume_reg;
    logic [7:0]  freq_lo_reg;
    logic [7:0]  freq_hi_reg;
    logic        enabled_reg;
    logic [11:0] half_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_len_reg <= RST_DUTY_LEN;
            volume_reg   <= RST_VOLUME;
            freq_lo_reg  <= RST_FREQ_LO;
            freq_hi_reg  <= RST_FREQ_HI;
            enabled_reg  <= 1'b1;
        end
        else if (wr.en)
        begin
            case (wr.idx)
                REG_DUTY_LEN: duty_len_reg <= wr.data;
                REG_VOLUME:   volume_reg   <= wr.data;
                REG_FREQ_LO:  freq_lo_reg  <= wr.data;
                REG_FREQ_HI:
                begin
                    freq_hi_reg <= wr.data;
                    // trigger: re-enable the channel
                    if (wr.data[7])
                    begin
                        enabled_reg <= 1'b1;
                    end
                end
                default: freq_hi_reg <= freq_hi_reg;
            endcase
        end
    end

    always_comb
    begin
        case (rd_idx)
            REG_DUTY_LEN: rd_data = duty_len_reg;
            REG_VOLUME:   rd_data = volume_reg;
            REG_FREQ_LO:  rd_data = freq_lo_reg;
            default:      rd_data = freq_hi_reg;
        endcase
    end

    // period = (2048 - freq) * 4, never zero
    assign half_period   = FREQ_BASE - {1'b0, freq_hi_reg[2:0], freq_lo_reg};
    assign view.period   = {half_period, 2'b00};
    assign view.duty_sel = duty_len_reg[7:6];
    assign view.volume   = volume_reg[7:4];
    assign view.enabled  = enabled_reg;

endmodule

@@ verif/square_wave_channel_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the square wave channel: tracks the channel state and compares result words
module square_wave_channel_checker
    import swc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], reg_index[3:2], write_data[11:4],
                                   // clock_count[19:12], zero[23:20]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // read_data[7:0], sample[11:8], channel_on[12],
                                   // zero[15:13]
    output int          fail_count,
    output int          pending,
    output int          compared
);

    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] clock_count;
        logic [7:0] write_data;
        logic [1:0] reg_index;
        logic [1:0] opcode;
    } bus_cmd_t;

    typedef struct packed {
        logic [2:0] pad;
        logic       channel_on;
        logic [3:0] sample;
        logic [7:0] read_data;
    } channel_out_t;

    logic [7:0]   duty_len;
    logic [7:0]   volume;
    logic [7:0]   freq_lo;
    logic [7:0]   freq_hi;
    logic [2:0]   duty_step;
    int           step_timer;
    logic         enabled;
    channel_out_t channel_outputs_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        compared   = 0;
    end

    function automatic int tone_period();
        return (int'(FREQ_BASE) - int'({freq_hi[2:0], freq_lo})) * 4;
    endfunction

    function automatic void reset_channel();
        duty_len   = RST_DUTY_LEN;
        volume     = RST_VOLUME;
        freq_lo    = RST_FREQ_LO;
        freq_hi    = RST_FREQ_HI;
        duty_step  = 3'd0;
        step_timer = tone_period();
        enabled    = 1'b1;
    endfunction

    // Carry the overrun past expiry into the following periods
    function automatic void run_clocks(input int clocks);
        int period;
        int over;
        period = tone_period();
        if (clocks >= step_timer)
        begin
            over       = clocks - step_timer;
            duty_step  = 3'((int'(duty_step) + 1 + over / period) & 7);
            step_timer = period - over % period;
        end
        else
            step_timer = step_timer - clocks;
    endfunction

    function automatic channel_out_t channel_step(input bus_cmd_t cmd);
        channel_out_t res;
        logic [7:0]   pattern;
        res = '0;
        case (cmd.opcode)
            OP_READ:
                case (cmd.reg_index)
                    REG_DUTY_LEN: res.read_data = duty_len;
                    REG_VOLUME:   res.read_data = volume;
                    REG_FREQ_LO:  res.read_data = freq_lo;
                    default:      res.read_data = freq_hi;
                endcase
            OP_WRITE:
                case (cmd.reg_index)
                    REG_DUTY_LEN: duty_len = cmd.write_data;
                    REG_VOLUME:   volume   = cmd.write_data;
                    REG_FREQ_LO:  freq_lo  = cmd.write_data;
                    default:
                    begin
                        // trigger reloads from the frequency held before this write
                        if (cmd.write_data[7])
                        begin
                            enabled    = 1'b1;
                            step_timer = tone_period();
                        end
                        freq_hi = cmd.write_data;
                    end
                endcase
            OP_ADVANCE: run_clocks(int'(cmd.clock_count));
            default: ;
        endcase
        pattern         = DUTY_PATTERN[duty_len[7:6]];
        res.sample      = pattern[duty_step] ? volume[7:4] : 4'd0;
        res.channel_on  = enabled;
        return res;
    endfunction

    function automatic void compare_word(input channel_out_t got);
        channel_out_t want;
        if (channel_outputs_q.size() == 0)
        begin
            fail_count++;
            $display("%0t: result word expected none, got %04h", $time, got);
            return;
        end
        want = channel_outputs_q.pop_front();
        compared++;
        if (got.read_data !== want.read_data)
        begin
            fail_count++;
            $display("%0t: read_data expected %02h, got %02h",
                     $time, want.read_data, got.read_data);
        end
        if (got.sample !== want.sample)
        begin
            fail_count++;
            $display("%0t: sample expected %0d, got %0d", $time, want.sample, got.sample);
        end
        if (got.channel_on !== want.channel_on)
        begin
            fail_count++;
            $display("%0t: channel_on expected %0b, got %0b",
                     $time, want.channel_on, got.channel_on);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_channel();
            channel_outputs_q.delete();
        end
        else
        begin
            // compare first: a result never belongs to the word taken on the same edge
            if (m_tvalid && m_tready)
                compare_word(channel_out_t'(m_tdata));
            if (s_tvalid && s_tready)
                channel_outputs_q.push_back(channel_step(bus_cmd_t'(s_tdata)));
        end
        pending = channel_outputs_q.size();
    end

endmodule

@@ verif/square_wave_channel_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the square wave channel: stimulus, handshake pacing and verdict
module square_wave_channel_tb;
    import swc_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_WORDS = 1100;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 32;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int fail_count;
    int pending;
    int compared;

    int rx_hold    = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    int n_words    = 0;
    int n_reads    = 0;
    int n_writes   = 0;
    int n_triggers = 0;
    int n_ticks    = 0;
    int n_unused   = 0;

    square_wave_channel u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    square_wave_channel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .compared   (compared)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] op, input logic [1:0] idx,
                             input logic [7:0] data, input logic [7:0] clocks);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        case (op)
            OP_READ:    n_reads++;
            OP_WRITE:   n_writes++;
            OP_ADVANCE: n_ticks++;
            default:    n_unused++;
        endcase
        if (op == OP_WRITE && idx == REG_FREQ_HI && data[7])
            n_triggers++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, clocks, data, idx, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_words++;
        @(negedge clk);
    endtask

    // Retune to a short period, trigger, then let time run
    task automatic play_note();
        int steps;
        steps = $urandom_range(2, 6);
        send_word(OP_WRITE, REG_FREQ_LO, 8'($urandom), 8'($urandom));
        send_word(OP_WRITE, REG_FREQ_HI, {1'b1, 4'($urandom), 3'($urandom_range(4, 7))},
                  8'($urandom));
        repeat (steps)
            send_word(OP_ADVANCE, 2'($urandom), 8'($urandom), 8'($urandom_range(64, 255)));
    endtask

    initial
    begin
        int         start;
        int         iter;
        int         pick;
        logic [1:0] idx;
        logic [7:0] data;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // reset values, unused opcode, tick extremes, write extremes
        send_word(OP_READ, REG_DUTY_LEN, 8'h00, 8'h00);
        send_word(OP_READ, REG_VOLUME, 8'h00, 8'h00);
        send_word(OP_READ, REG_FREQ_LO, 8'h00, 8'h00);
        send_word(OP_READ, REG_FREQ_HI, 8'h00, 8'h00);
        send_word(OP_UNUSED, 2'd3, 8'hFF, 8'hFF);
        send_word(OP_ADVANCE, 2'd0, 8'h00, 8'h00);
        send_word(OP_ADVANCE, 2'd0, 8'h00, 8'hFF);
        send_word(OP_WRITE, REG_DUTY_LEN, 8'hFF, 8'h00);
        send_word(OP_WRITE, REG_VOLUME, 8'h00, 8'h00);
        send_word(OP_WRITE, REG_VOLUME, 8'hFF, 8'h00);
        // shortest period without trigger: the old timer runs on above the period
        send_word(OP_WRITE, REG_FREQ_LO, 8'hFF, 8'h00);
        send_word(OP_WRITE, REG_FREQ_HI, 8'h07, 8'h00);
        send_word(OP_ADVANCE, 2'd0, 8'h00, 8'hFF);
        send_word(OP_WRITE, REG_FREQ_HI, 8'h87, 8'h00);
        send_word(OP_ADVANCE, 2'd0, 8'h00, 8'hFF);
        // triggers that reload from the frequency held before the write
        send_word(OP_WRITE, REG_FREQ_LO, 8'h00, 8'h00);
        send_word(OP_WRITE, REG_FREQ_HI, 8'h80, 8'h00);
        send_word(OP_WRITE, REG_FREQ_HI, 8'hC0, 8'h00);
        send_word(OP_WRITE, REG_FREQ_LO, 8'hFF, 8'h00);
        send_word(OP_WRITE, REG_FREQ_HI, 8'h07, 8'h00);
        send_word(OP_ADVANCE, 2'd0, 8'h00, 8'hFF);
        send_word(OP_READ, REG_DUTY_LEN, 8'h00, 8'h00);
        send_word(OP_READ, REG_VOLUME, 8'h00, 8'h00);
        send_word(OP_READ, REG_FREQ_LO, 8'h00, 8'h00);
        send_word(OP_READ, REG_FREQ_HI, 8'h00, 8'h00);

        start = n_words - n_unused;
        iter  = 0;
        while (n_words - n_unused - start < RANDOM_WORDS)
        begin
            if (iter % 48 == 0)
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            // stall the output for a long stretch while words keep coming
            if (iter == 200)
            begin
                tx_burst = 1'b1;
                rx_hold  = LONG_HOLD;
            end
            // hold the input until the channel has drained
            if (iter == 500)
            begin
                s_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 15)
                play_note();
            else if (pick < 50)
                send_word(OP_ADVANCE, 2'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 65)
                send_word(OP_READ, 2'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 95)
            begin
                idx  = 2'($urandom);
                data = 8'($urandom);
                if (idx == REG_FREQ_HI && $urandom_range(0, 1) == 1)
                    data[2:0] = 3'b111;
                send_word(OP_WRITE, idx, data, 8'($urandom));
            end
            else
                send_word(OP_UNUSED, 2'($urandom), 8'($urandom), 8'($urandom));
            iter++;
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d words: %0d reads, %0d writes (%0d triggers), %0d ticks,",
                 n_words, n_reads, n_writes, n_triggers, n_ticks);
        $display("%0d unused; %0d result words compared, with a %0d-cycle output stall.",
                 n_unused, compared, LONG_HOLD);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls per word, one long hold on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d result words outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
